### rtl/core/kr_pkg.sv
// Package for the keypad code lock: sizes, register codes, reset values and
// the control and result structs shared by the lock core and its cells.
// No dependencies.
package kr_pkg;

  localparam int RING_DEPTH    = 16;
  localparam int KEY_BITS      = 4;
  localparam int CODE_ENTRIES  = 16;
  localparam int CODE_BITS     = CODE_ENTRIES * KEY_BITS;
  localparam int CODE_IDX_BITS = $clog2(CODE_ENTRIES);
  localparam int COUNT_BITS    = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = CODE_BITS;

  typedef logic [KEY_BITS-1:0]      key_t;
  typedef logic [CODE_BITS-1:0]     code_t;
  typedef logic [CODE_IDX_BITS-1:0] code_idx_t;
  typedef logic [COUNT_BITS-1:0]    count_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STORED_CODE,
    CFG_STAR_KEY,
    CFG_NONE_KEY,
    CFG_TIMEOUT_LIMIT
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CMP
  } ctrl_state_t;

  localparam code_t  STORED_CODE_RST   = 64'hFFFF_FFFF_FFA5_4321;
  localparam key_t   STAR_KEY_RST      = key_t'(10);
  localparam key_t   NONE_KEY_RST      = key_t'(15);
  localparam count_t TIMEOUT_LIMIT_RST = count_t'(50);
  localparam count_t COUNT_MAX         = '1;

  // Commands from the sequencer to the row of key cells
  typedef struct packed {
    logic clear;   // start of session: empty every cell
    logic shift;   // new key enters cell 0, older keys move up
    logic rotate;  // compare walk: every cell takes its older neighbor
    key_t key;     // key that enters cell 0 on shift
  } chain_ctl_t;

  typedef struct packed {
    logic led_on;
    logic touch_beep;
    logic wrong_beep;
    logic door_release;
    logic session_active;
  } result_t;

  // One key code of the stored code, entry 0 in the low bits
  function automatic key_t code_nib(input code_t code, input code_idx_t idx);
    return code[idx*KEY_BITS +: KEY_BITS];
  endfunction

endpackage

### rtl/core/kr_pad_if.sv
// Keypad request channel: valid/ready handshake with mode and key payload.
// Depends on kr_pkg.
interface kr_pad_if import kr_pkg::*; ();
  logic valid;
  logic ready;
  logic mode;
  key_t key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

### rtl/core/kr_result_if.sv
// Result channel of the lock: valid/ready handshake with the status pulses.
// Depends on kr_pkg.
interface kr_result_if import kr_pkg::*; ();
  logic valid;
  logic ready;
  logic led_on;
  logic touch_beep;
  logic wrong_beep;
  logic door_release;
  logic session_active;

  modport source (output valid, output led_on, output touch_beep, output wrong_beep,
                  output door_release, output session_active, input ready);
  modport sink   (input valid, input led_on, input touch_beep, input wrong_beep,
                  input door_release, input session_active, output ready);
endinterface

### rtl/core/kr_cell.sv
// One key cell of the typed-key row: holds one key code and loads it from
// its newer or older neighbor. Depends on kr_pkg.
module kr_cell import kr_pkg::*; (
  input  logic       clk,
  input  chain_ctl_t ctl,
  input  key_t       from_newer,
  input  key_t       from_older,
  output key_t       key_q
);

  // Clear on session start, shift on a new key, rotate during compare, else hold
  always_ff @(posedge clk) begin
    priority if (ctl.clear) begin
      key_q <= '0;
    end else if (ctl.shift) begin
      key_q <= from_newer;
    end else if (ctl.rotate) begin
      key_q <= from_older;
    end else begin
      key_q <= key_q;
    end
  end

endmodule

### rtl/core/kr_ctrl.sv
// Session sequencer of the keypad lock: configuration registers, session
// state, compare walk over the key cells and the result register.
// Depends on kr_pkg, kr_pad_if and kr_result_if.
module kr_ctrl import kr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  kr_pad_if.sink                   pad,
  kr_result_if.source              result,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  key_t                     head_key,
  output chain_ctl_t               chain
);

  // Configuration registers
  code_t  stored_code;
  key_t   star_key;
  key_t   none_key;
  count_t timeout_limit;

  // Session state
  ctrl_state_t st, st_next;
  logic        active;
  key_t        last_key;
  count_t      poll_count;
  code_idx_t   idx;
  logic        rvalid;
  result_t     res, res_next;
  logic        res_load;

  logic      accept;
  logic      timed_out;
  logic      key_new;
  logic      key_is_star;
  logic      poll_live;
  logic      cmp_start;
  logic      cmp_mismatch;
  logic      cmp_done;
  logic      star_found;
  code_idx_t star_at;

  // Take a request only when idle and the result slot is free
  assign pad.ready   = (st == ST_IDLE) && (!rvalid || result.ready);

  assign accept      = pad.valid && pad.ready;
  assign timed_out   = poll_count > timeout_limit;
  assign key_new     = (pad.key != none_key) && (pad.key != last_key);
  assign key_is_star = pad.key == star_key;
  assign poll_live   = pad.mode && active && !timed_out;
  assign cmp_start   = poll_live && key_new && key_is_star && star_found;

  // Compare the code entry at idx against the key now in the head cell
  assign cmp_mismatch = code_nib(stored_code, idx) != head_key;
  assign cmp_done     = cmp_mismatch || (idx == '0);

  // Find the first star in the stored code, lowest entry wins
  always_comb begin
    star_found = 1'b0;
    star_at    = '0;
    for (int i = CODE_ENTRIES - 1; i >= 0; i--) begin
      if (code_nib(stored_code, code_idx_t'(i)) == star_key) begin
        star_found = 1'b1;
        star_at    = code_idx_t'(i);
      end
    end
  end

  // Next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: if (accept && cmp_start) st_next = ST_CMP;
      ST_CMP:  if (cmp_done) st_next = ST_IDLE;
    endcase
  end

  // Outputs: cell commands and result value
  always_comb begin
    chain.clear  = accept && !pad.mode;
    chain.shift  = accept && poll_live && key_new;
    chain.rotate = st == ST_CMP;
    chain.key    = pad.key;
    res_load     = 1'b0;
    res_next     = '0;
    unique case (st)
      ST_IDLE: begin
        if (accept) begin
          priority if (!pad.mode) begin
            res_load                = 1'b1;
            res_next.led_on         = 1'b1;
            res_next.session_active = 1'b1;
          end else if (!active) begin
            res_load = 1'b1;
          end else if (timed_out) begin
            res_load            = 1'b1;
            res_next.wrong_beep = 1'b1;
          end else if (key_new && key_is_star) begin
            // no star in the stored code: fail at once, else start the walk
            if (!star_found) begin
              res_load            = 1'b1;
              res_next.touch_beep = 1'b1;
              res_next.wrong_beep = 1'b1;
            end
          end else begin
            res_load                = 1'b1;
            res_next.led_on         = 1'b1;
            res_next.session_active = 1'b1;
            res_next.touch_beep     = key_new;
          end
        end
      end
      ST_CMP: begin
        if (cmp_done) begin
          res_load              = 1'b1;
          res_next.touch_beep   = 1'b1;
          res_next.wrong_beep   = cmp_mismatch;
          res_next.door_release = !cmp_mismatch;
        end
      end
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      active        <= 1'b0;
      last_key      <= NONE_KEY_RST;
      poll_count    <= '0;
      rvalid        <= 1'b0;
      stored_code   <= STORED_CODE_RST;
      star_key      <= STAR_KEY_RST;
      none_key      <= NONE_KEY_RST;
      timeout_limit <= TIMEOUT_LIMIT_RST;
    end else begin
      st <= st_next;

      // Hold the result until taken
      if (res_load) begin
        rvalid <= 1'b1;
        active <= res_next.session_active;
      end else if (result.ready) begin
        rvalid <= 1'b0;
      end

      if (accept && (!pad.mode || (active && !timed_out))) begin
        last_key <= pad.key;
      end

      // Saturating poll count
      if (accept && !pad.mode) begin
        poll_count <= '0;
      end else if (accept && active && (poll_count != COUNT_MAX)) begin
        poll_count <= poll_count + count_t'(1);
      end

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_STORED_CODE:   stored_code   <= cfg_data[CODE_BITS-1:0];
          CFG_STAR_KEY:      star_key      <= cfg_data[KEY_BITS-1:0];
          CFG_NONE_KEY:      none_key      <= cfg_data[KEY_BITS-1:0];
          CFG_TIMEOUT_LIMIT: timeout_limit <= cfg_data[COUNT_BITS-1:0];
        endcase
      end
    end
  end

  // Payload: result value and compare index
  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
    if (accept) begin
      idx <= star_at;
    end else if (st == ST_CMP) begin
      idx <= idx - code_idx_t'(1);
    end
  end

  assign result.valid          = rvalid;
  assign result.led_on         = res.led_on;
  assign result.touch_beep     = res.touch_beep;
  assign result.wrong_beep     = res.wrong_beep;
  assign result.door_release   = res.door_release;
  assign result.session_active = res.session_active;

endmodule

### rtl/core/keypad_code_lock_core.sv
// Keypad code lock top level: a row of key cells that keeps the typed keys,
// newest first, and the session sequencer. Depends on kr_pkg, kr_pad_if,
// kr_result_if, kr_cell and kr_ctrl.
//
//   channel  | dir | payload                                           | handshake
//   ---------+-----+---------------------------------------------------+-------------
//   pad      | in  | mode, key                                         | valid/ready
//   result   | out | led_on, touch_beep, wrong_beep, door_release,     | valid/ready
//            |     | session_active                                    |
//   cfg      | in  | cfg_index, cfg_data                               | cfg_we
//
// Start, poll and non-star key requests give their result in the cycle after
// acceptance. A star key runs a compare walk: the cell row rotates one cell
// per cycle while the head cell is checked against one stored entry, from
// the star's entry down to entry 0 or to the first mismatch. One request is
// in work at a time; a result not yet taken blocks the pad channel. Reset is
// synchronous and active high; no clearing pass is needed because a session
// start empties the cell row.
module keypad_code_lock_core import kr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  kr_pad_if.sink                   pad,
  kr_result_if.source              result,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  chain_ctl_t chain;
  key_t       cell_key [RING_DEPTH];

  // Row of key cells: new keys enter at cell 0, the compare walk rotates back
  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    kr_cell u_cell (
      .clk        (clk),
      .ctl        (chain),
      .from_newer ((i == 0) ? chain.key : cell_key[(i + RING_DEPTH - 1) % RING_DEPTH]),
      .from_older (cell_key[(i + 1) % RING_DEPTH]),
      .key_q      (cell_key[i])
    );
  end

  kr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pad       (pad),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head_key  (cell_key[0]),
    .chain     (chain)
  );

endmodule

### rtl/core/kr_checker.sv
// Port-level checks of the keypad lock result channel and its back-pressure,
// bound to keypad_code_lock_core. Depends on the top level's port list.
module kr_checker (
  input logic clk,
  input logic rst,
  input logic pad_valid,
  input logic pad_ready,
  input logic res_valid,
  input logic res_ready,
  input logic led_on,
  input logic touch_beep,
  input logic wrong_beep,
  input logic door_release,
  input logic session_active
);

  // A session ends either open or wrong, never both
  a_end_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(door_release && wrong_beep))
    else $error("door_release and wrong_beep in one result");

  // An ending pulse leaves no session behind
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (door_release || wrong_beep)) |-> (!session_active && !led_on))
    else $error("session still active after an ending pulse");

  // A door release always comes with a touch beep
  a_door_touch: assert property (@(posedge clk) disable iff (rst)
    (res_valid && door_release) |-> touch_beep)
    else $error("door_release without touch_beep");

  // A waiting result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !pad_ready)
    else $error("request taken while a result waits");

  // A stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(led_on) && $stable(touch_beep)
      && $stable(wrong_beep) && $stable(door_release) && $stable(session_active)))
    else $error("stalled result changed");

endmodule

bind keypad_code_lock_core kr_checker u_kr_checker (
  .clk            (clk),
  .rst            (rst),
  .pad_valid      (pad.valid),
  .pad_ready      (pad.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .led_on         (result.led_on),
  .touch_beep     (result.touch_beep),
  .wrong_beep     (result.wrong_beep),
  .door_release   (result.door_release),
  .session_active (result.session_active)
);
